// ===== sv/tat_pkg.sv =====
package tat_pkg;

   localparam int KEY_W  = 12;
   localparam int TIME_W = 32;
   localparam int MIN_W  = 16;

   localparam logic [MIN_W-1:0] MIN_AVOID_RESET = 16'd10000;

   typedef enum logic [1:0] {
      OP_SET    = 2'd0,
      OP_QUERY  = 2'd1,
      OP_REMOVE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_INIT_WIPE,
      ST_IDLE,
      ST_PREP,
      ST_SCAN,
      ST_WRITE,
      ST_CLEAR,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic start;     // capture the request and restart the sweep
      logic calc;      // form the new expiry time
      logic scan;      // read the table and test the entries
      logic write;     // write the chosen slot
      logic wipe;      // zero the slot under the sweep counter
      logic load_rsp;  // move the result into the output register
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   negative;
      logic   hit;
      logic   last;
      logic   wipe_last;
      logic   rsp_free;
   } status_type;

endpackage

// ===== sv/tat_req_if.sv =====
interface tat_req_if;
   logic                                valid;
   logic                                ready;
   tat_pkg::op_type                     operation;
   logic [tat_pkg::KEY_W-1:0]           item_key;
   logic signed [tat_pkg::TIME_W-1:0]   avoid_ms;
   logic [tat_pkg::TIME_W-1:0]          now_ms;

   modport source (output valid, operation, item_key, avoid_ms, now_ms, input ready);
   modport sink (input valid, operation, item_key, avoid_ms, now_ms, output ready);
endinterface

// ===== sv/tat_rsp_if.sv =====
interface tat_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [tat_pkg::TIME_W-1:0]  remaining_ms;
   logic                        blocked;

   modport source (output valid, remaining_ms, blocked, input ready);
   modport sink (input valid, remaining_ms, blocked, output ready);
endinterface

// ===== sv/tat_csr_if.sv =====
interface tat_csr_if;
   logic                       valid;
   logic                       ready;
   logic [tat_pkg::MIN_W-1:0]  min_avoid_ms;

   modport source (output valid, min_avoid_ms, input ready);
   modport sink (input valid, min_avoid_ms, output ready);
endinterface

// ===== sv/tat_ctrl.sv =====
module tat_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  tat_pkg::status_type status,
   output tat_pkg::cmd_type    cmd
);
   import tat_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT_WIPE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_INIT_WIPE: begin
            cmd.wipe = 1'b1;
            if (status.wipe_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.calc = 1'b1;
            priority if (status.op == OP_CLEAR) begin
               state_in = ST_CLEAR;
            end else if (status.op == OP_SET && status.negative) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            // A query only reads; a set ends with one write, and a remove writes only when it finds its key.
            priority if (status.hit) begin
               state_in = (status.op == OP_QUERY) ? ST_RESP : ST_WRITE;
            end else if (status.last) begin
               state_in = (status.op == OP_SET) ? ST_WRITE : ST_RESP;
            end
         end
         ST_WRITE: begin
            cmd.write = 1'b1;
            state_in  = ST_RESP;
         end
         ST_CLEAR: begin
            cmd.wipe = 1'b1;
            if (status.wipe_last) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/tat_dpath.sv =====
module tat_dpath #(
   parameter int SLOTS = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tat_pkg::op_type               req_operation,
   input  logic [tat_pkg::KEY_W-1:0]     req_item_key,
   input  logic signed [tat_pkg::TIME_W-1:0] req_avoid_ms,
   input  logic [tat_pkg::TIME_W-1:0]    req_now_ms,
   tat_csr_if.sink                       csr_bus,
   tat_rsp_if.source                     rsp_bus,
   input  tat_pkg::cmd_type              cmd,
   output tat_pkg::status_type           status
);
   import tat_pkg::*;

   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam int EW = KEY_W + TIME_W;

   // Request fields held for the whole operation, the expiry time and the minimum-duration register.
   op_type              op_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [TIME_W-1:0]   avoid_ff;
   logic [TIME_W-1:0]   now_ff;
   logic [TIME_W-1:0]   expiry_ff;
   logic [MIN_W-1:0]    min_ff;

   // Sweep counter and the registered read port.
   logic [CW-1:0]       cnt_ff;
   logic                rd_vld_ff;
   logic [AW-1:0]       rd_idx_ff;
   logic [EW-1:0]       rd_data_ff;

   logic                hit_ff;
   logic [AW-1:0]       tgt_ff;
   logic                free_ff;
   logic [AW-1:0]       free_idx_ff;
   logic [TIME_W-1:0]   rem_ff;
   logic                blk_ff;

   logic                rsp_valid_ff;
   logic [TIME_W-1:0]   rsp_rem_ff;
   logic                rsp_blk_ff;

   logic [EW-1:0]       mem [SLOTS];

   logic                rd_en;
   logic [KEY_W-1:0]    rd_key;
   logic [TIME_W-1:0]   rd_exp;
   logic                key_eq;
   logic                hit_now;
   logic                mem_we;
   logic [AW-1:0]       mem_waddr;
   logic [EW-1:0]       mem_wdata;
   logic [TIME_W-1:0]   dur;
   logic [TIME_W:0]     sum;

   assign rd_en   = cmd.scan && (cnt_ff < CW'(SLOTS));
   assign rd_key  = rd_data_ff[EW-1:TIME_W];
   assign rd_exp  = rd_data_ff[TIME_W-1:0];
   assign key_eq  = (rd_key == key_ff);
   assign hit_now = cmd.scan && rd_vld_ff && key_eq &&
                    ((op_ff != OP_QUERY) || (rd_exp >= now_ff));

   // Sign bit already screens out negative durations, so the low bits are the value.
   assign dur = (avoid_ff < TIME_W'(min_ff)) ? TIME_W'(min_ff) : avoid_ff;
   assign sum = {1'b0, now_ff} + {1'b0, dur};

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = cnt_ff[AW-1:0];
      mem_wdata = '0;
      if (cmd.wipe) begin
         mem_we = 1'b1;
      end else if (cmd.write) begin
         mem_we = 1'b1;
         priority if (hit_ff) begin
            mem_waddr = tgt_ff;
         end else if (free_ff) begin
            mem_waddr = free_idx_ff;
         end else begin
            mem_waddr = '0;
         end
         if (op_ff == OP_SET) begin
            mem_wdata = {key_ff, expiry_ff};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[cnt_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         min_ff       <= MIN_AVOID_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_vld_ff <= rd_en;
         if (cmd.start) begin
            cnt_ff <= '0;
         end else if (cmd.wipe || rd_en) begin
            cnt_ff <= cnt_ff + CW'(1);
         end
         if (csr_bus.valid) begin
            min_ff <= csr_bus.min_avoid_ms;
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= cnt_ff[AW-1:0];
      if (cmd.start) begin
         op_ff       <= req_operation;
         key_ff      <= req_item_key;
         avoid_ff    <= req_avoid_ms;
         now_ff      <= req_now_ms;
         hit_ff      <= 1'b0;
         free_ff     <= 1'b0;
         rem_ff      <= '0;
         blk_ff      <= 1'b0;
      end else if (cmd.scan) begin
         if (hit_now) begin
            hit_ff <= 1'b1;
            tgt_ff <= rd_idx_ff;
            if (op_ff == OP_QUERY) begin
               rem_ff <= rd_exp - now_ff;
               blk_ff <= 1'b1;
            end
         end
         if (rd_vld_ff && !free_ff && (rd_exp < now_ff)) begin
            free_ff     <= 1'b1;
            free_idx_ff <= rd_idx_ff;
         end
      end
      if (cmd.calc) begin
         expiry_ff <= sum[TIME_W] ? '1 : sum[TIME_W-1:0];
      end
      if (cmd.load_rsp) begin
         rsp_rem_ff <= rem_ff;
         rsp_blk_ff <= blk_ff;
      end
   end

   assign csr_bus.ready        = 1'b1;
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.remaining_ms = rsp_rem_ff;
   assign rsp_bus.blocked      = rsp_blk_ff;

   assign status.op        = op_ff;
   assign status.negative  = avoid_ff[TIME_W-1];
   assign status.hit       = hit_now;
   assign status.last      = cmd.scan && rd_vld_ff && (rd_idx_ff == AW'(SLOTS - 1));
   assign status.wipe_last = (cnt_ff == CW'(SLOTS - 1));
   assign status.rsp_free  = !rsp_valid_ff || rsp_bus.ready;

endmodule

// ===== sv/timed_avoid_table_unit.sv =====
// Table of SLOTS (key, expiry) slots that blocks item keys for a while. Each request beat
// (set, query, remove or clear) yields exactly one response beat; only a query that finds a
// live slot answers with blocked high and the time left. The table sits in one memory with a
// single write port and one registered read port, and every operation except clear and a
// negative set walks it one slot per cycle, stopping at the first slot that decides the
// answer. After reset the block zeroes the table before it takes its first request; the
// min_avoid_ms register can be written at any time and is ready at once. A new request is
// taken while an earlier response still waits.
module timed_avoid_table_unit #(
   parameter int SLOTS = 256
) (
   input  logic        clock,
   input  logic        reset,
   tat_req_if.sink     req_bus,
   tat_rsp_if.source   rsp_bus,
   tat_csr_if.sink     csr_bus
);
   import tat_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   assign req_bus.ready = req_ready;

   tat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tat_dpath #(
      .SLOTS (SLOTS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .req_operation (req_bus.operation),
      .req_item_key  (req_bus.item_key),
      .req_avoid_ms  (req_bus.avoid_ms),
      .req_now_ms    (req_bus.now_ms),
      .csr_bus       (csr_bus),
      .rsp_bus       (rsp_bus),
      .cmd           (cmd),
      .status        (status)
   );

endmodule
